// ===== rtl/core/fp32_gemm_engine_unit_macros.svh =====
// Assertion macros used by the checker module of the matrix engine.
`ifndef FP32_GEMM_ENGINE_UNIT_MACROS_SVH
`define FP32_GEMM_ENGINE_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FGEMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define FGEMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fgemm_pkg.sv =====
package fgemm_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_INNER = 16;
  localparam int MAX_COLS  = 16;

  localparam int IDX_W  = 4;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int SIZE_W = 5;
  localparam int DATA_W = 32;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [31:0] PINF = 32'h7F80_0000;

  typedef enum logic [2:0] {
    ACT_WR_A    = 3'd0,
    ACT_WR_B    = 3'd1,
    ACT_WR_C    = 3'd2,
    ACT_COMPUTE = 3'd3,
    ACT_RD_Y    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_READ  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_INNER = 2'd1,
    REG_COLS  = 2'd2,
    REG_BIAS  = 2'd3
  } reg_idx_e;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_RD_WAIT = 9'b000000010,
    ST_C_RD    = 9'b000000100,
    ST_C_LD    = 9'b000001000,
    ST_K_RD    = 9'b000010000,
    ST_K_GO    = 9'b000100000,
    ST_K_WAIT  = 9'b001000000,
    ST_Y_WR    = 9'b010000000,
    ST_RESP    = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] inner;
    logic [SIZE_W-1:0] cols;
    logic              bias;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic acc_load;
    logic fma_start;
    logic acc_update;
    logic k_inc;
    logic y_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_compute;
    logic in_read_ok;
    logic fma_done;
    logic k_last;
    logic ij_last;
  } stat_t;

endpackage

// ===== rtl/core/fgemm_cfg.sv =====
module fgemm_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output fgemm_pkg::cfg_t      cfg_o
);

  logic [fgemm_pkg::SIZE_W-1:0] rows_q, rows_d, inner_q, inner_d, cols_q, cols_d;
  logic                         bias_q, bias_d;
  logic                         wr_en;
  logic [fgemm_pkg::SIZE_W-1:0] wsize;
  fgemm_pkg::reg_idx_e          idx;

  // Size writes keep five bits; zero acts as one and anything above the maximum as the
  // maximum.
  function automatic logic [fgemm_pkg::SIZE_W-1:0] clamp(input logic [4:0] v,
                                                         input int max_v);
    logic [fgemm_pkg::SIZE_W-1:0] r;
    r = v;
    if (v == 5'd0) r = 5'd1;
    else if (int'(v) > max_v) r = fgemm_pkg::SIZE_W'(max_v);
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = fgemm_pkg::reg_idx_e'(paddr[3:2]);
  assign wsize  = pwdata[4:0];

  always_comb begin
    rows_d  = rows_q;
    inner_d = inner_q;
    cols_d  = cols_q;
    bias_d  = bias_q;
    prdata  = '0;
    unique case (idx)
      fgemm_pkg::REG_ROWS: begin
        prdata = {27'd0, rows_q};
        if (wr_en) rows_d = clamp(wsize, fgemm_pkg::MAX_ROWS);
      end
      fgemm_pkg::REG_INNER: begin
        prdata = {27'd0, inner_q};
        if (wr_en) inner_d = clamp(wsize, fgemm_pkg::MAX_INNER);
      end
      fgemm_pkg::REG_COLS: begin
        prdata = {27'd0, cols_q};
        if (wr_en) cols_d = clamp(wsize, fgemm_pkg::MAX_COLS);
      end
      fgemm_pkg::REG_BIAS: begin
        prdata = {31'd0, bias_q};
        if (wr_en) bias_d = pwdata[0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= fgemm_pkg::SIZE_W'(fgemm_pkg::MAX_ROWS);
      inner_q <= fgemm_pkg::SIZE_W'(fgemm_pkg::MAX_INNER);
      cols_q  <= fgemm_pkg::SIZE_W'(fgemm_pkg::MAX_COLS);
      bias_q  <= 1'b0;
    end else begin
      rows_q  <= rows_d;
      inner_q <= inner_d;
      cols_q  <= cols_d;
      bias_q  <= bias_d;
    end
  end

  assign cfg_o = '{rows: rows_q, inner: inner_q, cols: cols_q, bias: bias_q};

endmodule

// ===== rtl/core/fgemm_fma.sv =====
module fgemm_fma (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic        done_o,
  output logic [31:0] result_o
);

  // Six-stage pipeline: unpack and multiply, normalise, align, add, find the
  // leading one, round and pack.
  logic [5:0] v_q;

  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int b = 63; b >= 0; b--) begin
      if (!found) begin
        if (v[b]) found = 1'b1;
        else n = n + 7'd1;
      end
    end
    return n;
  endfunction

  // Stage 0: special operands, unpack, product.
  logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
  logic        ps, cs;
  logic [23:0] ma, mb, mc;
  logic signed [11:0] ea, eb, ec;
  logic        sp0;
  logic [31:0] sr0;

  assign a_nan  = a_i[30:0] > fgemm_pkg::PINF[30:0];
  assign b_nan  = b_i[30:0] > fgemm_pkg::PINF[30:0];
  assign c_nan  = c_i[30:0] > fgemm_pkg::PINF[30:0];
  assign a_inf  = a_i[30:0] == fgemm_pkg::PINF[30:0];
  assign b_inf  = b_i[30:0] == fgemm_pkg::PINF[30:0];
  assign c_inf  = c_i[30:0] == fgemm_pkg::PINF[30:0];
  assign a_zero = a_i[30:0] == 31'd0;
  assign b_zero = b_i[30:0] == 31'd0;
  assign c_zero = c_i[30:0] == 31'd0;
  assign ps     = a_i[31] ^ b_i[31];
  assign cs     = c_i[31];

  assign ma = (a_i[30:23] == 8'd0) ? {1'b0, a_i[22:0]} : {1'b1, a_i[22:0]};
  assign mb = (b_i[30:23] == 8'd0) ? {1'b0, b_i[22:0]} : {1'b1, b_i[22:0]};
  assign mc = (c_i[30:23] == 8'd0) ? {1'b0, c_i[22:0]} : {1'b1, c_i[22:0]};
  assign ea = (a_i[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a_i[30:23]}) - 12'sd150;
  assign eb = (b_i[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b_i[30:23]}) - 12'sd150;
  assign ec = (c_i[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, c_i[30:23]}) - 12'sd150;

  always_comb begin
    sp0 = 1'b1;
    sr0 = '0;
    if (a_nan || b_nan || c_nan) begin
      sr0 = fgemm_pkg::QNAN;
    end else if (a_inf || b_inf) begin
      if (a_zero || b_zero) sr0 = fgemm_pkg::QNAN;
      else if (c_inf && (cs != ps)) sr0 = fgemm_pkg::QNAN;
      else sr0 = {ps, fgemm_pkg::PINF[30:0]};
    end else if (c_inf) begin
      sr0 = c_i;
    end else if (a_zero || b_zero) begin
      if (c_zero) sr0 = (cs == ps) ? c_i : 32'd0;
      else sr0 = c_i;
    end else begin
      sp0 = 1'b0;
    end
  end

  logic        s1_sp_q, s1_cz_q, s1_ps_q, s1_cs_q;
  logic [31:0] s1_sr_q;
  logic [47:0] s1_mp_q;
  logic [23:0] s1_mc_q;
  logic signed [11:0] s1_ep_q, s1_ec_q;

  always_ff @(posedge clk_i) begin
    s1_sp_q <= sp0;
    s1_sr_q <= sr0;
    s1_cz_q <= c_zero;
    s1_ps_q <= ps;
    s1_cs_q <= cs;
    s1_mp_q <= ma * mb;
    s1_ep_q <= ea + eb;
    s1_mc_q <= mc;
    s1_ec_q <= ec;
  end

  // Stage 1: move the leading one of both operands to bit 61.
  logic [6:0]  shp, shc;
  logic [61:0] xp, xc;

  assign shp = 7'd14 + lzc64({s1_mp_q, 16'd0});
  assign shc = 7'd38 + lzc64({s1_mc_q, 40'd0});
  assign xp  = {14'd0, s1_mp_q} << shp;
  assign xc  = {38'd0, s1_mc_q} << shc;

  logic        s2_sp_q, s2_cz_q, s2_ps_q, s2_cs_q;
  logic [31:0] s2_sr_q;
  logic [61:0] s2_mp_q, s2_mc_q;
  logic signed [11:0] s2_ep_q, s2_ec_q;

  always_ff @(posedge clk_i) begin
    s2_sp_q <= s1_sp_q;
    s2_sr_q <= s1_sr_q;
    s2_cz_q <= s1_cz_q;
    s2_ps_q <= s1_ps_q;
    s2_cs_q <= s1_cs_q;
    s2_mp_q <= xp;
    s2_mc_q <= xc;
    s2_ep_q <= s1_ep_q - $signed({5'd0, shp});
    s2_ec_q <= s1_ec_q - $signed({5'd0, shc});
  end

  // Stage 2: the larger magnitude becomes x; y is shifted right with a sticky bit.
  logic        x_is_p, sx, sy;
  logic [61:0] xm, ym, yv, ysh;
  logic signed [11:0] ex, ey, dd;

  always_comb begin
    x_is_p = s2_cz_q || (s2_ep_q > s2_ec_q) ||
             ((s2_ep_q == s2_ec_q) && (s2_mp_q >= s2_mc_q));
    xm  = x_is_p ? s2_mp_q : s2_mc_q;
    ym  = x_is_p ? s2_mc_q : s2_mp_q;
    ex  = x_is_p ? s2_ep_q : s2_ec_q;
    ey  = x_is_p ? s2_ec_q : s2_ep_q;
    sx  = x_is_p ? s2_ps_q : s2_cs_q;
    sy  = x_is_p ? s2_cs_q : s2_ps_q;
    dd  = ex - ey;
    ysh = ym >> dd[5:0];
    if (s2_cz_q) yv = '0;
    else if (dd >= 12'sd62) yv = 62'd1;
    else if (dd > 12'sd0) yv = ysh | {61'd0, ((ysh << dd[5:0]) != ym)};
    else yv = ym;
  end

  logic        s3_sp_q, s3_sx_q, s3_sub_q;
  logic [31:0] s3_sr_q;
  logic [61:0] s3_x_q, s3_y_q;
  logic signed [11:0] s3_e_q;

  always_ff @(posedge clk_i) begin
    s3_sp_q  <= s2_sp_q;
    s3_sr_q  <= s2_sr_q;
    s3_sx_q  <= sx;
    s3_sub_q <= sx != sy;
    s3_x_q   <= xm;
    s3_y_q   <= yv;
    s3_e_q   <= ex;
  end

  // Stage 3: magnitude add or subtract.
  logic [62:0] rsum;
  assign rsum = s3_sub_q ? ({1'b0, s3_x_q} - {1'b0, s3_y_q}) :
                           ({1'b0, s3_x_q} + {1'b0, s3_y_q});

  logic        s4_sp_q, s4_sx_q;
  logic [31:0] s4_sr_q;
  logic [62:0] s4_r_q;
  logic signed [11:0] s4_e_q;

  always_ff @(posedge clk_i) begin
    // Exact cancellation gives positive zero.
    s4_sp_q <= s3_sp_q | (rsum == 63'd0);
    s4_sr_q <= s3_sp_q ? s3_sr_q : 32'd0;
    s4_sx_q <= s3_sx_q;
    s4_r_q  <= rsum;
    s4_e_q  <= s3_e_q;
  end

  // Stage 4: leading one of the sum, biased exponent and rounding position.
  logic [6:0]  pos;
  logic signed [11:0] biased, sft;
  logic [39:0] base;

  always_comb begin
    pos    = 7'd62 - lzc64({s4_r_q, 1'b0});
    biased = $signed({5'd0, pos}) + s4_e_q + 12'sd127;
    if (biased >= 12'sd1) begin
      sft  = $signed({5'd0, pos}) - 12'sd23;
      base = {28'd0, 12'(biased - 12'sd1)} << 23;
    end else begin
      sft  = -12'sd149 - s4_e_q;
      base = '0;
    end
  end

  logic        s5_sp_q, s5_sx_q;
  logic [31:0] s5_sr_q;
  logic [62:0] s5_r_q;
  logic signed [11:0] s5_s_q;
  logic [39:0] s5_base_q;

  always_ff @(posedge clk_i) begin
    s5_sp_q   <= s4_sp_q;
    s5_sr_q   <= s4_sr_q;
    s5_sx_q   <= s4_sx_q;
    s5_r_q    <= s4_r_q;
    s5_s_q    <= sft;
    s5_base_q <= base;
  end

  // Stage 5: round to nearest even and pack, saturating to infinity.
  logic [63:0] rw, mm, mask, rem, half;
  logic signed [11:0] nsft;
  logic [5:0]  sh;
  logic [39:0] packed_v;
  logic [31:0] res5;

  always_comb begin
    rw   = {1'b0, s5_r_q};
    nsft = -s5_s_q;
    sh   = s5_s_q[5:0];
    mask = (64'd1 << sh) - 64'd1;
    rem  = rw & mask;
    half = 64'd1 << (sh - 6'd1);
    if (s5_s_q <= 12'sd0) begin
      mm = rw << nsft[5:0];
    end else if (s5_s_q >= 12'sd64) begin
      mm = '0;
    end else begin
      mm = rw >> sh;
      if ((rem > half) || ((rem == half) && mm[0])) mm = mm + 64'd1;
    end
    packed_v = s5_base_q + mm[39:0];
    if (packed_v >= {8'd0, fgemm_pkg::PINF}) packed_v = {8'd0, fgemm_pkg::PINF};
    res5 = s5_sp_q ? s5_sr_q : {s5_sx_q, packed_v[30:0]};
  end

  logic [31:0] res_q;
  always_ff @(posedge clk_i) begin
    res_q <= res5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[4:0], start_i};
  end

  assign done_o   = v_q[5];
  assign result_o = res_q;

endmodule

// ===== rtl/core/fgemm_dp.sv =====
module fgemm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fgemm_pkg::cmd_t                   cmd_i,
  input  fgemm_pkg::cfg_t                   cfg_i,
  input  logic [2:0]                        action_i,
  input  logic [fgemm_pkg::IDX_W-1:0]       row_i,
  input  logic [fgemm_pkg::IDX_W-1:0]       col_i,
  input  logic [fgemm_pkg::DATA_W-1:0]      value_i,
  output fgemm_pkg::stat_t                  stat_o,
  output logic [fgemm_pkg::DATA_W-1:0]      read_value_o,
  output logic [1:0]                        status_o
);

  localparam int Depth = 1 << fgemm_pkg::ADDR_W;

  logic [fgemm_pkg::DATA_W-1:0] a_mem [Depth];
  logic [fgemm_pkg::DATA_W-1:0] b_mem [Depth];
  logic [fgemm_pkg::DATA_W-1:0] c_mem [Depth];
  logic [fgemm_pkg::DATA_W-1:0] y_mem [Depth];
  logic [fgemm_pkg::DATA_W-1:0] a_rd_q, b_rd_q, c_rd_q, y_rd_q;

  logic [fgemm_pkg::IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [fgemm_pkg::IDX_W-1:0] row_q, col_q;
  logic [2:0]                  action_q;
  logic                        ok_q, in_ok;
  logic [fgemm_pkg::DATA_W-1:0] acc_q, fma_res;
  logic                        fma_done;
  logic                        j_last, i_last;
  logic [fgemm_pkg::ADDR_W-1:0] in_addr;
  logic [fgemm_pkg::DATA_W-1:0] rv_d;
  fgemm_pkg::status_e          st_d;
  logic [1:0]                  st_q;
  logic [fgemm_pkg::DATA_W-1:0] rv_q;

  always_comb begin
    case (action_i)
      fgemm_pkg::ACT_WR_A:    in_ok = ({1'b0, row_i} < cfg_i.rows) && ({1'b0, col_i} < cfg_i.inner);
      fgemm_pkg::ACT_WR_B:    in_ok = ({1'b0, row_i} < cfg_i.inner) && ({1'b0, col_i} < cfg_i.cols);
      fgemm_pkg::ACT_WR_C,
      fgemm_pkg::ACT_RD_Y:    in_ok = ({1'b0, row_i} < cfg_i.rows) && ({1'b0, col_i} < cfg_i.cols);
      fgemm_pkg::ACT_COMPUTE: in_ok = 1'b1;
      default:                in_ok = 1'b0;
    endcase
  end

  assign in_addr = {row_i, col_i};

  // Element loads go straight into the stores on the accepting edge.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_ok && (action_i == fgemm_pkg::ACT_WR_A)) a_mem[in_addr] <= value_i;
    if (cmd_i.accept && in_ok && (action_i == fgemm_pkg::ACT_WR_B)) b_mem[in_addr] <= value_i;
    if (cmd_i.accept && in_ok && (action_i == fgemm_pkg::ACT_WR_C)) c_mem[in_addr] <= value_i;
    if (cmd_i.y_write) y_mem[{i_q, j_q}] <= acc_q;
    a_rd_q <= a_mem[{i_q, k_q}];
    b_rd_q <= b_mem[{k_q, j_q}];
    c_rd_q <= c_mem[{i_q, j_q}];
    y_rd_q <= y_mem[{row_q, col_q}];
  end

  assign j_last = {1'b0, j_q} == (cfg_i.cols - 5'd1);
  assign i_last = {1'b0, i_q} == (cfg_i.rows - 5'd1);

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    if (cmd_i.accept) begin
      i_d = '0;
      j_d = '0;
      k_d = '0;
    end else if (cmd_i.k_inc) begin
      k_d = k_q + 1'b1;
    end else if (cmd_i.y_write) begin
      k_d = '0;
      if (j_last) begin
        j_d = '0;
        i_d = i_q + 1'b1;
      end else begin
        j_d = j_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_i;
      ok_q     <= in_ok;
      row_q    <= row_i;
      col_q    <= col_i;
    end
    if (cmd_i.acc_load) acc_q <= cfg_i.bias ? c_rd_q : '0;
    else if (cmd_i.acc_update) acc_q <= fma_res;
  end

  fgemm_fma u_fma (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.fma_start),
    .a_i      (a_rd_q),
    .b_i      (b_rd_q),
    .c_i      (acc_q),
    .done_o   (fma_done),
    .result_o (fma_res)
  );

  always_comb begin
    rv_d = '0;
    st_d = fgemm_pkg::STAT_RANGE;
    case (action_q)
      fgemm_pkg::ACT_WR_A,
      fgemm_pkg::ACT_WR_B,
      fgemm_pkg::ACT_WR_C:    st_d = ok_q ? fgemm_pkg::STAT_OK : fgemm_pkg::STAT_RANGE;
      fgemm_pkg::ACT_COMPUTE: st_d = fgemm_pkg::STAT_OK;
      fgemm_pkg::ACT_RD_Y: begin
        if (ok_q) begin
          st_d = fgemm_pkg::STAT_READ;
          rv_d = y_rd_q;
        end
      end
      default: st_d = fgemm_pkg::STAT_RANGE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rv_q <= rv_d;
      st_q <= st_d;
    end
  end

  assign read_value_o = rv_q;
  assign status_o     = st_q;

  assign stat_o = '{
    in_compute: action_i == fgemm_pkg::ACT_COMPUTE,
    in_read_ok: (action_i == fgemm_pkg::ACT_RD_Y) && in_ok,
    fma_done:   fma_done,
    k_last:     {1'b0, k_q} == (cfg_i.inner - 5'd1),
    ij_last:    i_last && j_last
  };

endmodule

// ===== rtl/core/fgemm_ctrl.sv =====
module fgemm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  fgemm_pkg::stat_t stat_i,
  output fgemm_pkg::cmd_t  cmd_o
);

  fgemm_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = state_q == fgemm_pkg::ST_IDLE;
    unique case (state_q)
      fgemm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.in_compute) state_d = fgemm_pkg::ST_C_RD;
          else if (stat_i.in_read_ok) state_d = fgemm_pkg::ST_RD_WAIT;
          else state_d = fgemm_pkg::ST_RESP;
        end
      end
      fgemm_pkg::ST_RD_WAIT: state_d = fgemm_pkg::ST_RESP;
      fgemm_pkg::ST_C_RD:    state_d = fgemm_pkg::ST_C_LD;
      fgemm_pkg::ST_C_LD: begin
        cmd_o.acc_load = 1'b1;
        state_d        = fgemm_pkg::ST_K_GO;
      end
      fgemm_pkg::ST_K_RD:    state_d = fgemm_pkg::ST_K_GO;
      fgemm_pkg::ST_K_GO: begin
        cmd_o.fma_start = 1'b1;
        state_d         = fgemm_pkg::ST_K_WAIT;
      end
      fgemm_pkg::ST_K_WAIT: begin
        if (stat_i.fma_done) begin
          cmd_o.acc_update = 1'b1;
          if (stat_i.k_last) begin
            state_d = fgemm_pkg::ST_Y_WR;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = fgemm_pkg::ST_K_RD;
          end
        end
      end
      fgemm_pkg::ST_Y_WR: begin
        cmd_o.y_write = 1'b1;
        state_d = stat_i.ij_last ? fgemm_pkg::ST_RESP : fgemm_pkg::ST_C_RD;
      end
      fgemm_pkg::ST_RESP: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = fgemm_pkg::ST_IDLE;
        end
      end
      default: state_d = fgemm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fgemm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/fp32_gemm_engine_unit.sv =====
// Channel    | Handshake                  | Payload
// -----------+----------------------------+------------------------------------
// input      | in_valid_i / in_ready_o    | action_i, row_i, col_i, value_i
// output     | out_valid_o / out_ready_i  | read_value_o, status_o
// config     | psel, penable, pwrite      | paddr, pwdata, prdata (pready high)
//
// Load and rejected items go from the accept straight to the response; Y reads first
// wait for the registered store read. In a compute, every accumulation step runs once
// through the six-stage fused multiply-add unit before the next may start.
// An item is taken while an earlier result still waits in the output register; its
// own result then holds until that register is free. Reset is asynchronous and active
// low; the stores hold no reset and need no clearing pass.
module fp32_gemm_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    action_i,
  input  logic [fgemm_pkg::IDX_W-1:0]   row_i,
  input  logic [fgemm_pkg::IDX_W-1:0]   col_i,
  input  logic [fgemm_pkg::DATA_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fgemm_pkg::DATA_W-1:0]  read_value_o,
  output logic [1:0]                    status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  fgemm_pkg::cfg_t  cfg;
  fgemm_pkg::cmd_t  cmd;
  fgemm_pkg::stat_t stat;

  fgemm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fgemm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fgemm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .action_i     (action_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .stat_o       (stat),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

endmodule

// ===== rtl/core/fgemm_chk.sv =====
`include "fp32_gemm_engine_unit_macros.svh"

module fgemm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_value_o,
  input logic [1:0]  status_o,
  input logic        pready
);

  // A result that is not taken must stay on the port unchanged.
  `FGEMM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(read_value_o) && $stable(status_o), "stalled result transaction changed")

  `FGEMM_ASSERT(a_status_code, !out_valid_o || (status_o <= fgemm_pkg::STAT_RANGE), "undefined status code")

  // Only a successful read carries data.
  `FGEMM_ASSERT(a_zero_data, !out_valid_o || (status_o == fgemm_pkg::STAT_READ) || (read_value_o == 32'd0), "data on a transaction that is not a read")

  `FGEMM_ASSERT(a_pready, pready, "configuration port not ready")

endmodule

bind fp32_gemm_engine_unit fgemm_chk u_chk (.*);
